[rtl/linear_key_value_table_top_defines.svh]
// ----------------------------------------------------------------------------
// linear_key_value_table_top_defines
// assertion macros used by the key/value table top rtl
// ----------------------------------------------------------------------------
`ifndef LINEAR_KEY_VALUE_TABLE_TOP_DEFINES_SVH
`define LINEAR_KEY_VALUE_TABLE_TOP_DEFINES_SVH

// condition holds on every edge outside reset
`define LKVT_ASSERT_COND(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define LKVT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LKVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lkvt_pkg.sv]
// ----------------------------------------------------------------------------
// lkvt_pkg
// shared types and constants of the linear key/value table
// ----------------------------------------------------------------------------
package lkvt_pkg;

  localparam int DEPTH       = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 8;
  localparam int CAP_W       = 5;
  localparam int STATUS_W    = 3;

  localparam int INDEX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CAP_W > COUNT_W) ? CAP_W : COUNT_W;
  localparam int REC_W   = KEY_WIDTH + VALUE_WIDTH;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [STATUS_W-1:0] STATUS_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_UPDATED  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

[rtl/linear_key_value_table_top.sv]
// ----------------------------------------------------------------------------
// linear_key_value_table_top
// associative key/value table, filled in insertion order, searched linearly
// ----------------------------------------------------------------------------
//  channel   | signals                              | dir | handshake
//  ----------+--------------------------------------+-----+--------------------
//  request   | action, key, write_value             | in  | start && !busy
//  result    | status, read_value                   | out | done, one cycle
//  config    | cfg_wdata (capacity_limit)           | in  | cfg_we
//
//  an empty table answers without a scan; otherwise one ram read per filled
//  entry up to the match, and the result passes through an output register
//  the result strobe follows the decision cycle; busy is low in that cycle
//  rst (synchronous) empties the table and sets capacity_limit to 16
//  the receiver cannot stall; the ram read port sets the scan rate
// ----------------------------------------------------------------------------
`include "linear_key_value_table_top_defines.svh"

module linear_key_value_table_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             action,
  input  logic [lkvt_pkg::KEY_WIDTH-1:0]   key,
  input  logic [lkvt_pkg::VALUE_WIDTH-1:0] write_value,
  output logic                             done,
  output logic [lkvt_pkg::STATUS_W-1:0]    status,
  output logic [lkvt_pkg::VALUE_WIDTH-1:0] read_value,
  input  logic                             cfg_we,
  input  logic [lkvt_pkg::CAP_W-1:0]       cfg_wdata
);

  localparam int KW = lkvt_pkg::KEY_WIDTH;
  localparam int VW = lkvt_pkg::VALUE_WIDTH;
  localparam int IW = lkvt_pkg::INDEX_W;
  localparam int CW = lkvt_pkg::COUNT_W;
  localparam int MW = lkvt_pkg::CMP_W;
  localparam int RW = lkvt_pkg::REC_W;

  lkvt_pkg::state_t state, state_next;
  logic [IW-1:0]               scan_idx, scan_idx_next;
  logic [CW-1:0]               fill_count, fill_count_next;
  logic [lkvt_pkg::CAP_W-1:0]  capacity_limit;
  logic                        req_action;
  logic [KW-1:0]               req_key;
  logic [VW-1:0]               req_value;

  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  logic [RW-1:0]               ram_wdata;
  logic [IW-1:0]               ram_raddr;
  logic [RW-1:0]               ram_rdata;

  logic                        res_valid;
  logic [lkvt_pkg::STATUS_W-1:0] res_status;
  logic [VW-1:0]               res_value;

  logic                        cur_action;
  logic [KW-1:0]               cur_key;
  logic [VW-1:0]               cur_value;
  logic                        found;
  logic                        finish;
  logic                        last_entry;
  logic [MW-1:0]               cap_ext;
  logic [MW-1:0]               eff_cap;
  logic                        full;

  lkvt_ram #(
    .WIDTH (RW),
    .DEPTH (lkvt_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // capacity above the depth acts as the depth
  assign cap_ext    = MW'(capacity_limit);
  assign eff_cap    = (cap_ext > MW'(lkvt_pkg::DEPTH)) ? MW'(lkvt_pkg::DEPTH) : cap_ext;
  assign full       = MW'(fill_count) >= eff_cap;
  assign last_entry = (CW'(scan_idx) + CW'(1)) == fill_count;
  assign busy       = (state != lkvt_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= lkvt_pkg::ST_IDLE;
      fill_count     <= '0;
      capacity_limit <= lkvt_pkg::CAP_RESET;
      done           <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      done       <= res_valid;
      if (cfg_we) begin
        capacity_limit <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    if (start && !busy) begin
      req_action <= action;
      req_key    <= key;
      req_value  <= write_value;
    end
    if (res_valid) begin
      status     <= res_status;
      read_value <= res_value;
    end
  end

  always_comb begin
    state_next      = state;
    scan_idx_next   = scan_idx;
    fill_count_next = fill_count;
    ram_raddr       = '0;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    res_valid       = 1'b0;
    res_status      = lkvt_pkg::STATUS_MISS;
    res_value       = '0;
    cur_action      = req_action;
    cur_key         = req_key;
    cur_value       = req_value;
    found           = 1'b0;
    finish          = 1'b0;

    unique case (state)
      lkvt_pkg::ST_IDLE: begin
        cur_action = action;
        cur_key    = key;
        cur_value  = write_value;
        if (start) begin
          if (fill_count == '0) begin
            finish = 1'b1;
          end else begin
            state_next    = lkvt_pkg::ST_SCAN;
            scan_idx_next = '0;
            ram_raddr     = '0;
          end
        end
      end
      lkvt_pkg::ST_SCAN: begin
        ram_raddr = scan_idx + IW'(1);
        if (ram_rdata[RW-1:VW] == req_key) begin
          found  = 1'b1;
          finish = 1'b1;
        end else if (last_entry) begin
          finish = 1'b1;
        end else begin
          scan_idx_next = scan_idx + IW'(1);
        end
      end
    endcase

    if (finish) begin
      state_next = lkvt_pkg::ST_IDLE;
      res_valid  = 1'b1;
      if (!cur_action) begin
        if (found) begin
          res_status = lkvt_pkg::STATUS_HIT;
          res_value  = ram_rdata[VW-1:0];
        end else begin
          res_status = lkvt_pkg::STATUS_MISS;
        end
      end else if (found) begin
        res_status = lkvt_pkg::STATUS_UPDATED;
        ram_we     = 1'b1;
        ram_waddr  = scan_idx;
        ram_wdata  = {ram_rdata[RW-1:VW], cur_value};
      end else if (full) begin
        res_status = lkvt_pkg::STATUS_DROPPED;
      end else begin
        res_status      = lkvt_pkg::STATUS_INSERTED;
        ram_we          = 1'b1;
        ram_waddr       = fill_count[IW-1:0];
        ram_wdata       = {cur_key, cur_value};
        fill_count_next = fill_count + CW'(1);
      end
    end
  end

  `LKVT_ASSERT_COND(a_fill_bounded, fill_count <= CW'(lkvt_pkg::DEPTH), "fill count above depth")
  `LKVT_ASSERT_IMPL(a_done_not_busy, done, !busy, "result strobe while scanning")
  `LKVT_ASSERT_IMPL(a_value_zero, done && (status != lkvt_pkg::STATUS_HIT), read_value == '0, "read value set without hit")
  `LKVT_ASSERT_NEXT(a_start_progress, start && !busy, busy || done, "request neither scanned nor answered")
  `LKVT_ASSERT_IMPL(a_fill_on_insert, !$past(rst) && (fill_count != $past(fill_count)), done && (status == lkvt_pkg::STATUS_INSERTED), "fill count moved without insert")

endmodule

[rtl/lkvt_ram.sv]
// ----------------------------------------------------------------------------
// lkvt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module lkvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the linear key/value table, directed and random
// requests with capacity changes between phases
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = lkvt_pkg::DEPTH;
  localparam int KEY_WIDTH   = lkvt_pkg::KEY_WIDTH;
  localparam int VALUE_WIDTH = lkvt_pkg::VALUE_WIDTH;
  localparam int CAP_W       = lkvt_pkg::CAP_W;
  localparam int STATUS_W    = lkvt_pkg::STATUS_W;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_SET    = 1'b1;
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   PHASE_ITEMS = 60;

  typedef enum logic [1:0] {
    JOB_REQUEST,
    JOB_CAPACITY,
    JOB_DRAIN
  } job_kind_t;

  typedef struct {
    job_kind_t              kind;
    logic                   act;
    logic [KEY_WIDTH-1:0]   k;
    logic [VALUE_WIDTH-1:0] wv;
    logic [CAP_W-1:0]       cap;
    int                     gap;
  } job_t;

  typedef struct {
    logic [STATUS_W-1:0]    status;
    logic [VALUE_WIDTH-1:0] value;
  } answer_t;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   start       = 1'b0;
  logic                   action      = 1'b0;
  logic [KEY_WIDTH-1:0]   key         = '0;
  logic [VALUE_WIDTH-1:0] write_value = '0;
  logic                   cfg_we      = 1'b0;
  logic [CAP_W-1:0]       cfg_wdata   = '0;
  logic                   busy;
  logic                   done;
  logic [STATUS_W-1:0]    status;
  logic [VALUE_WIDTH-1:0] read_value;

  job_t    job_q[$];
  answer_t answer_q[$];

  // table model
  logic [KEY_WIDTH-1:0]   model_keys[DEPTH];
  logic [VALUE_WIDTH-1:0] model_values[DEPTH];
  int                     model_fill = 0;
  logic [CAP_W-1:0]       model_cap  = lkvt_pkg::CAP_RESET;

  logic [KEY_WIDTH-1:0] key_pool[$];

  int gap_left   = 0;
  bit gap_taken  = 1'b0;
  int n_requests = 0;
  int n_cap_wr   = 0;
  int n_results  = 0;
  int mismatches = 0;
  int cycles     = 0;
  int status_seen[5] = '{default: 0};

  linear_key_value_table_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .key        (key),
    .write_value(write_value),
    .done       (done),
    .status     (status),
    .read_value (read_value),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic answer_t lookup_or_set(input logic act, input logic [KEY_WIDTH-1:0] k,
                                            input logic [VALUE_WIDTH-1:0] wv);
    answer_t ans;
    int      at;
    int      room;
    at = -1;
    for (int i = 0; i < model_fill; i++) begin
      if (at < 0 && model_keys[i] == k) at = i;
    end
    room = (int'(model_cap) > DEPTH) ? DEPTH : int'(model_cap);
    ans.value = '0;
    if (act == ACT_LOOKUP) begin
      if (at >= 0) begin
        ans.status = lkvt_pkg::STATUS_HIT;
        ans.value  = model_values[at];
      end else begin
        ans.status = lkvt_pkg::STATUS_MISS;
      end
    end else if (at >= 0) begin
      model_values[at] = wv;
      ans.status = lkvt_pkg::STATUS_UPDATED;
    end else if (model_fill >= room) begin
      ans.status = lkvt_pkg::STATUS_DROPPED;
    end else begin
      model_keys[model_fill]   = k;
      model_values[model_fill] = wv;
      model_fill++;
      ans.status = lkvt_pkg::STATUS_INSERTED;
    end
    return ans;
  endfunction

  task automatic add_request(input logic act, input logic [KEY_WIDTH-1:0] k,
                             input logic [VALUE_WIDTH-1:0] wv, input int gap);
    job_t j;
    j.kind = JOB_REQUEST;
    j.act  = act;
    j.k    = k;
    j.wv   = wv;
    j.cap  = '0;
    j.gap  = gap;
    job_q.push_back(j);
  endtask

  task automatic add_job(input job_kind_t kind, input logic [CAP_W-1:0] cap);
    job_t j;
    j.kind = kind;
    j.act  = ACT_LOOKUP;
    j.k    = '0;
    j.wv   = '0;
    j.cap  = cap;
    j.gap  = 0;
    job_q.push_back(j);
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on result %0d, %s: expected %0h, got %0h", n_results, what,
               want, got);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start  <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      if (start && !busy) begin
        answer_q.push_back(lookup_or_set(action, key, write_value));
        n_requests++;
      end
      if (start && busy) begin
        cfg_we <= 1'b0;
      end else if (gap_left > 0) begin
        start    <= 1'b0;
        cfg_we   <= 1'b0;
        gap_left = gap_left - 1;
      end else if (job_q.size() == 0) begin
        start  <= 1'b0;
        cfg_we <= 1'b0;
      end else if (job_q[0].kind == JOB_REQUEST && !gap_taken && job_q[0].gap > 0) begin
        start     <= 1'b0;
        cfg_we    <= 1'b0;
        gap_taken = 1'b1;
        gap_left  = job_q[0].gap - 1;
      end else if (job_q[0].kind == JOB_REQUEST) begin
        start       <= 1'b1;
        action      <= job_q[0].act;
        key         <= job_q[0].k;
        write_value <= job_q[0].wv;
        cfg_we      <= 1'b0;
        gap_taken   = 1'b0;
        void'(job_q.pop_front());
      end else if (start || answer_q.size() != 0) begin
        start  <= 1'b0;
        cfg_we <= 1'b0;
      end else if (job_q[0].kind == JOB_CAPACITY) begin
        cfg_we    <= 1'b1;
        cfg_wdata <= job_q[0].cap;
        model_cap = job_q[0].cap;
        n_cap_wr++;
        void'(job_q.pop_front());
      end else begin
        cfg_we <= 1'b0;
        void'(job_q.pop_front());
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      n_results++;
      if (answer_q.size() == 0) begin
        note_mismatch("unexpected result status", 0, status);
      end else begin
        want = answer_q.pop_front();
        if (status !== want.status) note_mismatch("status", want.status, status);
        if (read_value !== want.value) note_mismatch("read_value", want.value, read_value);
        if (want.status <= lkvt_pkg::STATUS_DROPPED) status_seen[want.status]++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, answer_q.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    logic [CAP_W-1:0]     phase_caps[8];
    logic [KEY_WIDTH-1:0] k;
    int                   gap;

    phase_caps = '{CAP_W'(5), CAP_W'(1), CAP_W'(9), CAP_W'(0), CAP_W'(12), CAP_W'(20),
                   CAP_W'(16), CAP_W'(31)};

    // directed opening
    add_request(ACT_LOOKUP, 32'h0000_0000, 8'h00, 0);
    add_request(ACT_SET,    32'h0000_0000, 8'h00, 0);
    add_request(ACT_SET,    32'hFFFF_FFFF, 8'hFF, 2);
    add_request(ACT_LOOKUP, 32'hFFFF_FFFF, 8'h00, 0);
    add_request(ACT_LOOKUP, 32'h0000_0000, 8'hFF, 0);
    add_request(ACT_SET,    32'h0000_0000, 8'hA5, 0);
    add_request(ACT_LOOKUP, 32'h0000_0000, 8'h00, 1);
    add_request(ACT_LOOKUP, 32'h7FFF_FFFF, 8'h00, 0);
    add_request(ACT_LOOKUP, 32'hFFFF_FFFE, 8'h00, 0);
    add_request(ACT_SET,    32'h8000_0000, 8'h5A, 0);
    add_request(ACT_LOOKUP, 32'h8000_0000, 8'hFF, 3);
    add_request(ACT_SET,    32'hFFFF_FFFF, 8'h00, 0);
    add_request(ACT_LOOKUP, 32'hFFFF_FFFF, 8'h00, 0);
    // zero capacity
    add_job(JOB_CAPACITY, CAP_W'(0));
    add_request(ACT_SET,    32'h1234_5678, 8'h11, 0);
    add_request(ACT_SET,    32'h0000_0000, 8'h3C, 0);
    add_request(ACT_LOOKUP, 32'h1234_5678, 8'h00, 0);
    add_request(ACT_LOOKUP, 32'h0000_0000, 8'h00, 0);
    // capacity below the fill
    add_job(JOB_CAPACITY, CAP_W'(2));
    add_request(ACT_SET,    32'h1234_5678, 8'h22, 0);
    add_request(ACT_SET,    32'h8000_0000, 8'hC3, 0);
    add_request(ACT_LOOKUP, 32'h8000_0000, 8'h00, 0);
    // capacity above depth
    add_job(JOB_CAPACITY, CAP_W'(31));
    add_request(ACT_SET,    32'h1234_5678, 8'h33, 0);
    add_request(ACT_LOOKUP, 32'h1234_5678, 8'h00, 0);

    key_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678};
    for (int i = 0; i < 12; i++) key_pool.push_back($urandom);
    for (int i = 0; i < 8; i++) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      key_pool.push_back(k ^ (32'h1 << $urandom_range(0, KEY_WIDTH - 1)));
    end

    // random phases, one capacity setting each
    foreach (phase_caps[p]) begin
      add_job(JOB_CAPACITY, phase_caps[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && (p == 2 || p == 5)) add_job(JOB_DRAIN, '0);
        if ($urandom_range(0, 3) == 0) k = $urandom;
        else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        gap = 0;
        if (p < 7 && (i % 32) < 20 && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 13);
        add_request(1'($urandom_range(0, 1)), k, 8'($urandom_range(0, 255)), gap);
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (job_q.size() != 0 || start || answer_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d requests, %0d results over %0d capacity writes, final fill %0d of %0d",
             n_requests, n_results, n_cap_wr, model_fill, DEPTH);
    $display("hit %0d, miss %0d, updated %0d, inserted %0d, dropped %0d; %0d mismatches",
             status_seen[lkvt_pkg::STATUS_HIT], status_seen[lkvt_pkg::STATUS_MISS],
             status_seen[lkvt_pkg::STATUS_UPDATED], status_seen[lkvt_pkg::STATUS_INSERTED],
             status_seen[lkvt_pkg::STATUS_DROPPED], mismatches);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
